>>> rtl/nfbs_pkg.sv
package nfbs_pkg;

    // page address bits that reach the flash; the page field is always 16 bits wide
    localparam int PAGE_ADDR_BITS = 16;
    localparam logic [15:0] PAGE_MASK = (PAGE_ADDR_BITS >= 16) ? 16'hFFFF
                                      : 16'((32'd1 << PAGE_ADDR_BITS) - 32'd1);

    localparam int MAX_ITEMS   = 5;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // flash command bytes
    localparam logic [7:0] CMD_RDID     = 8'h90;
    localparam logic [7:0] CMD_MAIN     = 8'h00;
    localparam logic [7:0] CMD_HALF     = 8'h01;
    localparam logic [7:0] CMD_SPARE    = 8'h50;
    localparam logic [7:0] CMD_PROG     = 8'h80;
    localparam logic [7:0] CMD_PROG_END = 8'h10;
    localparam logic [7:0] CMD_ERASE    = 8'h60;
    localparam logic [7:0] CMD_ERASE_GO = 8'hD0;
    localparam logic [7:0] CMD_STATUS   = 8'h70;

    typedef enum logic [2:0] {
        OP_READ_ID    = 3'd0,
        OP_START_READ = 3'd1,
        OP_START_PROG = 3'd2,
        OP_WRITE_BYTE = 3'd3,
        OP_END_PROG   = 3'd4,
        OP_ERASE      = 3'd5,
        OP_READ_BYTE  = 3'd6,
        OP_POLL_READY = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        K_CMD    = 3'd0,
        K_ADDR   = 3'd1,
        K_WRITE  = 3'd2,
        K_READ   = 3'd3,
        K_DONE   = 3'd4,
        K_REJECT = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_ID    = 3'd1,
        M_RWAIT = 3'd2,
        M_RDATA = 3'd3,
        M_PDATA = 3'd4,
        M_BUSY  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        AREA_MAIN  = 2'd0,
        AREA_HALF  = 2'd1,
        AREA_SPARE = 2'd2,
        AREA_NONE  = 2'd3
    } area_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       wp_open;
    } item_t;

    // one request's worth of bus cycles, item 0 goes out first
    typedef struct packed {
        item_t [MAX_ITEMS-1:0] items;
        logic  [CNT_W-1:0]     cnt;
    } desc_t;

    function automatic item_t mk_item(kind_t k, logic [7:0] v, logic wp);
        item_t it;
        it.kind    = k;
        it.value   = v;
        it.wp_open = wp;
        return it;
    endfunction

endpackage

>>> rtl/nand_flash_bus_sequencer.sv
// Small-page x8 NAND bus sequencer.
// Request channel: in_valid / in_stall with op, area, page, column, data_byte,
// flash_byte and ready_line; a transfer happens on a clock edge with in_valid
// high and in_stall low. Result channel: out_valid / out_stall with kind,
// value, write_enable_open and last; last marks the final bus cycle of a request.
// The front decodes each request against the current mode at once and queues
// the list of bus cycles it causes (one to five); a poll while the flash is
// busy causes none and is simply absorbed. The back plays one cycle per clock
// into an output register while out_stall is low.
// The first result of a request passes through the queue and then the output
// register before out_valid rises.
// A request occupies the back until its last bus cycle is loaded, so the
// sustained request rate is set by the back's one-item-per-clock output
// register. The front takes a new request every clock while the
// two-entry queue has room; in_stall is the queue full flag.
// Reset: mode returns to idle, write protect locked, queue and output empty.
// When the receiver stalls, the output register holds its transfer, the back
// stops, the queue fills and then in_stall rises.
module nand_flash_bus_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [1:0]  area,
    input  logic [15:0] page,
    input  logic [7:0]  column,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  flash_byte,
    input  logic        ready_line,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  value,
    output logic        write_enable_open,
    output logic        last
);
    import nfbs_pkg::*;

    logic  push, pop, q_valid, q_full;
    desc_t wr_desc, rd_desc;

    assign in_stall = q_full;

    // decode and mode tracking
    nfbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .area       (area),
        .page       (page),
        .column     (column),
        .data_byte  (data_byte),
        .flash_byte (flash_byte),
        .ready_line (ready_line),
        .push       (push),
        .desc       (wr_desc)
    );

    // decouples decode from bus-cycle playback
    nfbs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_desc  (wr_desc),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_desc  (rd_desc),
        .full     (q_full)
    );

    // one bus cycle per clock into the output register while out_stall is low
    nfbs_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_desc            (rd_desc),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .value             (value),
        .write_enable_open (write_enable_open),
        .last              (last)
    );

endmodule

>>> rtl/nfbs_front.sv
module nfbs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  logic [2:0]    op,
    input  logic [1:0]    area,
    input  logic [15:0]   page,
    input  logic [7:0]    column,
    input  logic [7:0]    data_byte,
    input  logic [7:0]    flash_byte,
    input  logic          ready_line,
    output logic          push,
    output nfbs_pkg::desc_t desc
);
    import nfbs_pkg::*;

    mode_t      mode_reg, mode_next;
    logic       prot_reg, prot_next;
    logic [15:0] pg;
    logic [7:0] plo, phi;
    logic       can_start;
    logic       accept;

    assign accept = in_valid && !in_stall;
    assign pg  = page & PAGE_MASK;
    assign plo = pg[7:0];
    assign phi = pg[15:8];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            prot_reg <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            prot_reg <= prot_next;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        prot_next = prot_reg;
        desc      = '0;
        can_start = (mode_reg == M_IDLE) || (mode_reg == M_ID) || (mode_reg == M_RDATA)
                 || (mode_reg != M_RWAIT && mode_reg != M_PDATA && mode_reg != M_BUSY);
        // rejected unless an arm below fills the list or empties it
        desc.items[0] = mk_item(K_REJECT, 8'h00, prot_reg);
        desc.cnt      = CNT_W'(1);
        case (op)
            OP_READ_ID: begin
                if (can_start) begin
                    prot_next     = 1'b0;
                    desc.items[0] = mk_item(K_CMD, CMD_RDID, 1'b0);
                    desc.items[1] = mk_item(K_ADDR, 8'h00, 1'b0);
                    desc.cnt      = CNT_W'(2);
                    mode_next     = M_ID;
                end
            end
            OP_START_READ: begin
                if (can_start) begin
                    prot_next     = 1'b0;
                    desc.items[0] = mk_item(K_CMD, (area == AREA_MAIN) ? CMD_MAIN : CMD_SPARE,
                                            1'b0);
                    desc.items[1] = mk_item(K_ADDR, column, 1'b0);
                    desc.items[2] = mk_item(K_ADDR, plo, 1'b0);
                    desc.items[3] = mk_item(K_ADDR, phi, 1'b0);
                    desc.cnt      = CNT_W'(4);
                    mode_next     = M_RWAIT;
                end
            end
            OP_START_PROG: begin
                if (can_start && area != AREA_NONE) begin
                    prot_next     = 1'b1;
                    desc.items[0] = mk_item(K_CMD, (area == AREA_MAIN) ? CMD_MAIN
                                            : ((area == AREA_HALF) ? CMD_HALF : CMD_SPARE),
                                            1'b1);
                    desc.items[1] = mk_item(K_CMD, CMD_PROG, 1'b1);
                    desc.items[2] = mk_item(K_ADDR, column, 1'b1);
                    desc.items[3] = mk_item(K_ADDR, plo, 1'b1);
                    desc.items[4] = mk_item(K_ADDR, phi, 1'b1);
                    desc.cnt      = CNT_W'(5);
                    mode_next     = M_PDATA;
                end
            end
            OP_WRITE_BYTE: begin
                if (mode_reg == M_PDATA) begin
                    desc.items[0] = mk_item(K_WRITE, data_byte, prot_reg);
                end
            end
            OP_END_PROG: begin
                if (mode_reg == M_PDATA) begin
                    desc.items[0] = mk_item(K_CMD, CMD_PROG_END, prot_reg);
                    mode_next     = M_BUSY;
                end
            end
            OP_ERASE: begin
                if (can_start) begin
                    prot_next     = 1'b1;
                    desc.items[0] = mk_item(K_CMD, CMD_ERASE, 1'b1);
                    desc.items[1] = mk_item(K_ADDR, plo, 1'b1);
                    desc.items[2] = mk_item(K_ADDR, phi, 1'b1);
                    desc.items[3] = mk_item(K_CMD, CMD_ERASE_GO, 1'b1);
                    desc.cnt      = CNT_W'(4);
                    mode_next     = M_BUSY;
                end
            end
            OP_READ_BYTE: begin
                if (mode_reg == M_ID || mode_reg == M_RDATA) begin
                    desc.items[0] = mk_item(K_READ, flash_byte, prot_reg);
                end
            end
            default: begin
                // poll ready
                if (mode_reg == M_RWAIT) begin
                    if (!ready_line) begin
                        desc.cnt = '0;
                    end else begin
                        desc.items[0] = mk_item(K_DONE, 8'h00, prot_reg);
                        mode_next     = M_RDATA;
                    end
                end else if (mode_reg == M_BUSY) begin
                    if (!ready_line) begin
                        desc.cnt = '0;
                    end else begin
                        // pointer back to main area, then relock and read status
                        prot_next     = 1'b0;
                        desc.items[0] = mk_item(K_CMD, CMD_MAIN, prot_reg);
                        desc.items[1] = mk_item(K_CMD, CMD_STATUS, 1'b0);
                        desc.items[2] = mk_item(K_DONE, {7'd0, flash_byte[0]}, 1'b0);
                        desc.cnt      = CNT_W'(3);
                        mode_next     = M_IDLE;
                    end
                end
            end
        endcase
    end

    assign push = accept && (desc.cnt != '0);

endmodule

>>> rtl/nfbs_queue.sv
module nfbs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nfbs_pkg::desc_t wr_desc,
    input  logic            pop,
    output logic            rd_valid,
    output nfbs_pkg::desc_t rd_desc,
    output logic            full
);
    import nfbs_pkg::*;

    desc_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;

    assign rd_valid = (cnt_reg != '0);
    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_desc  = mem[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/nfbs_back.sv
module nfbs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  nfbs_pkg::desc_t q_desc,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      kind,
    output logic [7:0]      value,
    output logic            write_enable_open,
    output logic            last
);
    import nfbs_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    item_t            item_reg, item_next;
    logic             last_reg, last_next;
    logic             load, at_end;
    item_t            cur;

    assign cur    = q_desc.items[idx_reg];
    assign at_end = (CNT_W'(idx_reg) == q_desc.cnt - CNT_W'(1));
    assign load   = q_valid && (!out_valid_reg || !out_stall);
    assign pop    = load && at_end;

    always_comb begin
        idx_next       = idx_reg;
        item_next      = item_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load) begin
            item_next      = cur;
            last_next      = at_end;
            out_valid_next = 1'b1;
            idx_next       = at_end ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        item_reg <= item_next;
        last_reg <= last_next;
    end

    assign out_valid         = out_valid_reg;
    assign kind              = item_reg.kind;
    assign value             = item_reg.value;
    assign write_enable_open = item_reg.wp_open;
    assign last              = last_reg;

endmodule
